### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL. All sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

### rtl/pos_pkg.sv
// ----------------------------------------------------------------------------
// pos_pkg
// Widths, constants and register codes for the pitch offset smoothing block.
// ----------------------------------------------------------------------------
package pos_pkg;

  // Port widths
  localparam int SMP_W = 16;            // absolute sample, Q3.13
  localparam int OUT_W = 17;            // filtered result, Q4.13
  localparam int CFG_W = 16;            // widest config register
  localparam int CFG_IDX_W = 1;

  // Internal widths
  localparam int REL_W = SMP_W + 1;     // relative sample
  localparam int AVG_W = 33;            // running average, value times 2^16
  localparam int RES_W = REL_W + 1;     // unclipped result before deadband
  localparam int FRAC_SHIFT = 16;

  // Window of recent samples
  localparam int WIN_LEN = 5;
  localparam int FILL_W = $clog2(WIN_LEN + 1);
  localparam int SUM_W = REL_W + $clog2(WIN_LEN);

  // Division by WIN_LEN as multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = 26;
  localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + WIN_LEN - 1) / WIN_LEN;
  localparam int RECIP_W = $clog2(RECIP + 1);

  // Reset values of the config registers
  localparam logic [CFG_W-1:0] SMOOTH_RESET = 16'd3277;
  localparam logic [CFG_W-1:0] NOISE_RESET = 16'd164;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING = 1'b0,
    REG_NOISE     = 1'b1
  } cfg_reg_t;

endpackage

### rtl/pitch_offset_smoothing_deadband.sv
// An accepted word passes the s0, s1 and output registers in turn before it shows on out_*.
// Throughput: one word per cycle while out_stall is low; the running-average update (one 18x33
// multiply-add feeding back into its own register) sets the cycle.
// Reset: synchronous rst_n clears all valids, the offset latch, the fill
// count and the running average, and reloads the config registers.
// ----------------------------------------------------------------------------
// pitch_offset_smoothing_deadband
// Relative pitch smoother: first sample is the zero offset, exponential
// average until the window fills, then window mean, then a deadband.
// ----------------------------------------------------------------------------
module pitch_offset_smoothing_deadband (
  input  logic                              clk,
  input  logic                              rst_n,
  // config port
  input  logic                              cfg_we,
  input  logic [pos_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pos_pkg::CFG_W-1:0]         cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pos_pkg::SMP_W-1:0]  in_pitch_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pos_pkg::OUT_W-1:0]  out_pitch_filtered
);

  import pos_pkg::*;

  localparam int ACC_W = AVG_W + 18;
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [AVG_W:0] AVG_HALF = (AVG_W + 1)'(1) <<< (FRAC_SHIFT - 1);
  localparam int PROD_W = SUM_W + RECIP_W;

  // Config registers
  logic [CFG_W-1:0] smooth_r;
  logic [CFG_W-1:0] noise_r;

  // Filter state
  logic                    offset_taken_r;
  logic [SMP_W-1:0]        offset_r;
  logic [FILL_W-1:0]       fill_r;
  logic signed [AVG_W-1:0] avg_r;
  logic signed [REL_W-1:0] win_r [WIN_LEN];

  // Pipeline registers
  logic                    s0_valid_r;
  logic signed [SMP_W-1:0] s0_sample_r;
  logic                    s1_valid_r;
  logic                    s1_win_r;
  logic signed [AVG_W-1:0] s1_val_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_data_r;

  // Handshake
  logic s2_ready, s1_ready, s0_ready, s1_adv, s2_adv;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign s1_adv   = s0_valid_r && s1_ready;
  assign s2_adv   = s1_valid_r && s2_ready;
  assign in_stall = !s0_ready;

  // ---------------- stage 1: state update ----------------
  logic signed [REL_W-1:0]  base_s, rel_s;
  logic signed [REL_W:0]    alpha_s;
  logic [REL_W-1:0]         inv_u;
  logic signed [REL_W+REL_W:0] prod_new;
  logic signed [ACC_W-1:0]  prod_old;
  logic signed [ACC_W-1:0]  acc_s;
  logic signed [AVG_W-1:0]  avg_nxt;
  logic signed [REL_W-1:0]  win_nxt [WIN_LEN];
  logic signed [SUM_W-1:0]  sum_s;
  logic [FILL_W-1:0]        fill_nxt;
  logic                     full_s;
  logic signed [AVG_W-1:0]  s1_val_nxt;

  // relative sample; the very first one is zero by definition
  always_comb begin
    base_s = offset_taken_r ? REL_W'($signed(offset_r)) : REL_W'(s0_sample_r);
    rel_s  = REL_W'(s0_sample_r) - base_s;
  end

  // exponential average: A' = floor((a*r*2^16 + (2^16-a)*A + 2^15) / 2^16)
  always_comb begin
    alpha_s  = $signed({2'b00, smooth_r});
    inv_u    = REL_W'(18'h10000 - {2'b00, smooth_r});
    prod_new = alpha_s * rel_s;
    prod_old = $signed({1'b0, inv_u}) * avg_r;
    acc_s    = (ACC_W'(prod_new) <<< FRAC_SHIFT) + prod_old + ACC_HALF;
    avg_nxt  = acc_s[FRAC_SHIFT +: AVG_W];
  end

  // window shift and sum
  always_comb begin
    win_nxt[0] = rel_s;
    for (int i = 1; i < WIN_LEN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    sum_s = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      sum_s = sum_s + SUM_W'(win_nxt[i]);
    end
  end

  // fill count saturates at the window length
  always_comb begin
    fill_nxt   = (fill_r == FILL_W'(WIN_LEN)) ? fill_r : fill_r + FILL_W'(1);
    full_s     = (fill_nxt == FILL_W'(WIN_LEN));
    s1_val_nxt = full_s ? AVG_W'(sum_s) : avg_nxt;
  end

  // ---------------- stage 2: rounding and deadband ----------------
  logic signed [AVG_W:0]    avg_sum;
  logic signed [RES_W-1:0]  avg_res;
  logic signed [SUM_W-1:0]  sum_w;
  logic                     neg_w;
  logic [SUM_W-1:0]         mag_w, num_w;
  logic [PROD_W-1:0]        prod_w;
  logic [RES_W-2:0]         quo_w;
  logic signed [RES_W-1:0]  win_res, res_s, res_mag;
  logic                     dead_s;
  logic signed [OUT_W-1:0]  out_nxt;

  always_comb begin
    // average path: round half up to Q5.13
    avg_sum = (AVG_W + 1)'(s1_val_r) + AVG_HALF;
    avg_res = avg_sum[FRAC_SHIFT +: RES_W];
    // window path: divide magnitude, ties away from zero
    sum_w   = s1_val_r[SUM_W-1:0];
    neg_w   = sum_w[SUM_W-1];
    mag_w   = neg_w ? SUM_W'(-sum_w) : SUM_W'(sum_w);
    num_w   = mag_w + SUM_W'(WIN_LEN / 2);
    prod_w  = PROD_W'(num_w) * PROD_W'(RECIP);
    quo_w   = prod_w[RECIP_SHIFT +: (RES_W - 1)];
    win_res = neg_w ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
    // select and deadband
    res_s   = s1_win_r ? win_res : avg_res;
    res_mag = res_s[RES_W-1] ? -res_s : res_s;
    dead_s  = (res_mag < $signed({2'b00, noise_r}));
    out_nxt = dead_s ? '0 : res_s[OUT_W-1:0];
  end

  // ---------------- registers ----------------
  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= SMOOTH_RESET;
      noise_r  <= NOISE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SMOOTHING: smooth_r <= cfg_wdata;
        REG_NOISE:     noise_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r     <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      offset_taken_r <= 1'b0;
      offset_r       <= '0;
      fill_r         <= '0;
      avg_r          <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid_r <= in_valid;
      end
      if (s1_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        if (!offset_taken_r) begin
          offset_r <= s0_sample_r;
        end
        offset_taken_r <= 1'b1;
        fill_r         <= fill_nxt;
        avg_r          <= avg_nxt;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      s0_sample_r <= in_pitch_sample;
    end
    if (s1_adv) begin
      win_r    <= win_nxt;
      s1_win_r <= full_s;
      s1_val_r <= s1_val_nxt;
    end
    if (s2_adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pitch_filtered = out_data_r;

  // ---------------- assertions ----------------
`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(WIN_LEN), "fill count past window length")
  `ASSERT_NEXT(a_offset_sticky, offset_taken_r, offset_taken_r, "offset latch dropped")
  `ASSERT_IMPL(a_fill_needs_offset, fill_r != '0, offset_taken_r, "fill without offset")
  `ASSERT_IMPL(a_win_when_full, s1_valid_r && s1_win_r, fill_r == FILL_W'(WIN_LEN), "early mean")
  `ASSERT_NEXT(a_s2_load, s2_adv, out_valid_r, "result word lost at output register")

endmodule
